>>> hw/rtl/hslrgb_pkg.sv
package hslrgb_pkg;

  // Beat layouts
  localparam int unsigned InBits  = 40;  // 38 used bits, zero-padded to 5 bytes
  localparam int unsigned OutBits = 32;

  localparam int unsigned HueW  = 16;
  localparam int unsigned PctW  = 7;
  localparam int unsigned ChanW = 8;

  // Hue reduction
  localparam logic [9:0]  HueTurn  = 10'd360;
  localparam logic [16:0] HueBias  = 17'd33120;  // 92 turns, makes any 16-bit hue positive
  localparam int unsigned HueShift = 26;
  localparam logic [17:0] HueRecip = 18'(((64'd1 << HueShift) + 64'd359) / 64'd360);

  localparam logic [6:0] PctFull = 7'd100;

  // Channel scaling: value is V / 300000, output round(255 * value)
  localparam logic [20:0] ScaleDen  = 21'd300000;
  localparam logic [26:0] ScaleHalf = 27'd150000;
  localparam int unsigned ChanShift = 46;
  localparam logic [27:0] ChanRecip =
    28'(((64'd1 << ChanShift) + 64'd299999) / 64'd300000);

  // Sector offsets in degrees for green and blue (red has none)
  localparam logic [8:0] GreenOfs = 9'd240;
  localparam logic [8:0] BlueOfs  = 9'd120;

  function automatic logic [6:0] pct_sat(input logic [6:0] p);
    pct_sat = (p > PctFull) ? PctFull : p;
  endfunction

  // (r + ofs) mod 360, both operands below 360
  function automatic logic [8:0] deg_add(input logic [8:0] r, input logic [8:0] ofs);
    logic [9:0] sum;
    sum = {1'b0, r} + {1'b0, ofs};
    if (sum >= HueTurn) begin
      sum = sum - HueTurn;
    end
    deg_add = sum[8:0];
  endfunction

endpackage

>>> hw/rtl/hsl_to_rgb_converter.sv
// CSS Color 4 HSL to RGB, one pixel per beat. Input tdata carries hue (signed degrees, any
// value, reduced mod 360), saturation and lightness (percent, above 100 read as 100) and
// alpha; output tdata carries red, green, blue (each round-to-nearest of 255 times the
// channel value, half rounds up) and alpha copied through. The datapath is a six-stage
// pipeline with one valid bit per stage, so a new beat is taken on every clock unless the
// output is stalled. Sustained rate is one beat per clock while the output is not stalled.
// While the last stage holds a beat, a low m_axis_tready freezes the whole pipeline
// through one shared enable; with the last stage empty the pipeline keeps moving.
// s_axis_tready follows that enable combinationally, so nothing is dropped or repeated.
// The deepest stages are the hue reciprocal multiply (17 x 18 bits) and the final
// divide-by-300000 reciprocal multiply (27 x 28 bits), one per stage.
module hsl_to_rgb_converter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] hue_degrees, [22:16] saturation_pct, [29:23] lightness_pct,
  // [37:30] alpha_in, [39:38] zero
  input  logic [hslrgb_pkg::InBits-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [31:24] alpha_out
  output logic [hslrgb_pkg::OutBits-1:0] m_axis_tdata
);
  import hslrgb_pkg::*;

  localparam int unsigned Depth = 6;

  logic             en;
  logic [Depth:1]   vld_q;

  // one enable for every stage: advance unless the last stage holds a beat nobody takes
  assign en            = !vld_q[Depth] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-1:1], s_axis_tvalid};
    end
  end

  // input unpacking
  logic [HueW-1:0] hue_in;
  logic [PctW-1:0] sat_in, lit_in;
  logic [7:0]      alpha_in;

  assign hue_in   = s_axis_tdata[15:0];
  assign sat_in   = s_axis_tdata[22:16];
  assign lit_in   = s_axis_tdata[29:23];
  assign alpha_in = s_axis_tdata[37:30];

  // stage 1: bias hue positive, quotient by 360 from reciprocal multiply
  logic [17:0] hue_b;
  logic [34:0] hue_prod;
  logic [16:0] u1_q;
  logic [7:0]  q1_q;
  logic [6:0]  s1_q, l1_q;

  assign hue_b    = 18'($signed({hue_in[HueW-1], hue_in[HueW-1], hue_in})) + {1'b0, HueBias};
  assign hue_prod = 35'(hue_b[16:0]) * 35'(HueRecip);

  // stage 2: remainder and channel sector positions; percent limits and m
  logic [16:0] rem17;
  logic [8:0]  hdeg;
  logic [6:0]  sc, lc;
  logic [6:0]  lcomp;
  logic [8:0]  kr_q, kg_q, kb_q;
  logic [6:0]  s2_q, l2_q;
  logic [5:0]  m2_q, m_d;

  assign rem17 = u1_q - ({9'd0, q1_q} * 17'd360);
  assign hdeg  = rem17[8:0];
  assign sc    = pct_sat(s1_q);
  assign lc    = pct_sat(l1_q);
  assign lcomp = PctFull - lc;
  assign m_d   = (lc < lcomp) ? lc[5:0] : lcomp[5:0];

  // stage 3: shared products
  logic [12:0] sm3_q;
  logic [18:0] l3k3_q;

  // alpha rides alongside
  logic [7:0] alpha_q [Depth];

  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_q    <= hue_b[16:0];
      q1_q    <= hue_prod[HueShift +: 8];
      s1_q    <= sat_in;
      l1_q    <= lit_in;
      kr_q    <= hdeg;
      kg_q    <= deg_add(hdeg, GreenOfs);
      kb_q    <= deg_add(hdeg, BlueOfs);
      s2_q    <= sc;
      l2_q    <= lc;
      m2_q    <= m_d;
      sm3_q   <= 13'(s2_q) * 13'(m2_q);
      l3k3_q  <= 19'(l2_q) * 19'd3000;
      alpha_q[0] <= alpha_in;
      for (int i = 1; i < Depth; i++) begin
        alpha_q[i] <= alpha_q[i-1];
      end
    end
  end

  logic [7:0] red_o, green_o, blue_o;

  hslrgb_chan u_red (
    .clk_i  (clk_i),
    .en_i   (en),
    .kdeg_i (kr_q),
    .sm_i   (sm3_q),
    .l3k_i  (l3k3_q),
    .chan_o (red_o)
  );

  hslrgb_chan u_green (
    .clk_i  (clk_i),
    .en_i   (en),
    .kdeg_i (kg_q),
    .sm_i   (sm3_q),
    .l3k_i  (l3k3_q),
    .chan_o (green_o)
  );

  hslrgb_chan u_blue (
    .clk_i  (clk_i),
    .en_i   (en),
    .kdeg_i (kb_q),
    .sm_i   (sm3_q),
    .l3k_i  (l3k3_q),
    .chan_o (blue_o)
  );

  assign m_axis_tdata = {alpha_q[Depth-1], blue_o, green_o, red_o};

  // reduced hue and sector positions stay inside one turn
  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (kr_q < 9'd360) && (kg_q < 9'd360) && (kb_q < 9'd360))
    else $error("sector position out of range");

  // an open pipeline loads the input valid into the first stage
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> (vld_q[1] == $past(s_axis_tvalid)))
    else $error("stage 1 valid does not follow accepted input");

  // a stall freezes every stage
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

endmodule

>>> hw/rtl/hslrgb_chan.sv
module hslrgb_chan (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [8:0]  kdeg_i,  // sector position, stage 2
  input  logic [12:0] sm_i,    // S * m, stage 3
  input  logic [18:0] l3k_i,   // 3000 * L, stage 3
  output logic [7:0]  chan_o   // stage 6
);
  import hslrgb_pkg::*;

  // stage 3: clamp term T in -30..30
  logic signed [10:0] ka, kb, tmin;
  logic signed [5:0]  t_d, t_q;

  always_comb begin
    ka   = $signed({2'b00, kdeg_i}) - 11'sd90;
    kb   = 11'sd270 - $signed({2'b00, kdeg_i});
    tmin = (ka < kb) ? ka : kb;
    if (tmin > 11'sd30) begin
      tmin = 11'sd30;
    end
    if (tmin < -11'sd30) begin
      tmin = -11'sd30;
    end
    t_d = tmin[5:0];
  end

  // stage 4: V = 3000*L - S*m*T, limited to 0..300000
  logic signed [19:0] prod;
  logic signed [20:0] diff;
  logic [18:0]        v_d, v_q;

  always_comb begin
    prod = $signed({1'b0, sm_i}) * t_q;
    diff = $signed({2'b00, l3k_i}) - 21'(prod);
    if (diff < 21'sd0) begin
      v_d = '0;
    end else if (diff > $signed(ScaleDen)) begin
      v_d = ScaleDen[18:0];
    end else begin
      v_d = diff[18:0];
    end
  end

  // stage 5: 255*V + half
  logic [26:0] x_d, x_q;
  assign x_d = (27'(v_q) << 8) - 27'(v_q) + ScaleHalf;

  // stage 6: exact divide by 300000 via reciprocal
  logic [54:0] quo;
  logic [7:0]  chan_d, chan_q;
  assign quo    = 55'(x_q) * 55'(ChanRecip);
  assign chan_d = quo[ChanShift +: ChanW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q    <= t_d;
      v_q    <= v_d;
      x_q    <= x_d;
      chan_q <= chan_d;
    end
  end

  assign chan_o = chan_q;

endmodule

>>> tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hslrgb_pkg::*;

  // One input pixel and one expected output color
  typedef struct packed {
    logic signed [HueW-1:0] hue;
    logic [PctW-1:0]        sat;
    logic [PctW-1:0]        light;
    logic [7:0]             alpha;
  } hsl_pixel_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [7:0]       alpha;
  } rgba_color_t;

  localparam int unsigned RedOfs    = 0;  // degrees
  localparam int unsigned TailBeats = 200;  // no idling once this few pixels remain
  localparam int unsigned RandCount = 1650;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [InBits-1:0]  s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OutBits-1:0] m_tdata;

  hsl_pixel_t  pixel_q[$];  // pixels not yet offered
  rgba_color_t rgba_q[$];   // colors still owed by the DUT
  hsl_pixel_t  cur_pix = '0;

  int unsigned err_count = 0;
  int unsigned checked_count = 0;
  int unsigned directed_count = 0;
  int unsigned src_gap = 0, src_calm = 0, src_idle_cycles = 0;
  int unsigned sink_gap = 0, sink_calm = 0, sink_stall_cycles = 0;

  always #10 clk_i = ~clk_i;

  hsl_to_rgb_converter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  // One channel of the CSS formula, kept in whole degrees so the sector
  // position is exact. ofs_deg is 30*n (0 red, 240 green, 120 blue).
  function automatic logic [ChanW-1:0] css_channel(int h, int s, int l, int ofs_deg);
    int     k;
    int     t;
    int     m;
    longint v;
    k = (ofs_deg + h) % 360;
    t = k - 90;
    if (270 - k < t) t = 270 - k;
    if (t > 30) t = 30;
    if (t < -30) t = -30;
    m = (l < 100 - l) ? l : 100 - l;
    // v is the channel value scaled by 300000
    v = longint'(3000) * l - longint'(s) * m * t;
    if (v < 0) v = 0;
    if (v > 300000) v = 300000;
    return ChanW'((v * 255 + 150000) / 300000);
  endfunction

  function automatic rgba_color_t hsl_to_rgba(hsl_pixel_t p);
    rgba_color_t c;
    int          h;
    int          s;
    int          l;
    h = int'(p.hue) % 360;  // truncating remainder, fixed up below
    if (h < 0) h += 360;
    s = (p.sat > 100) ? 100 : int'(p.sat);
    l = (p.light > 100) ? 100 : int'(p.light);
    c.red   = css_channel(h, s, l, RedOfs);
    c.green = css_channel(h, s, l, int'(GreenOfs));
    c.blue  = css_channel(h, s, l, int'(BlueOfs));
    c.alpha = p.alpha;
    return c;
  endfunction

  function automatic void queue_pixel(int h, int s, int l, int a);
    hsl_pixel_t p;
    p.hue   = HueW'(h);
    p.sat   = PctW'(s);
    p.light = PctW'(l);
    p.alpha = 8'(a);
    pixel_q.push_back(p);
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < 40) $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued pixels, with random idle bursts and calm stretches.
  // The expected color is computed when the beat is actually accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drv
    logic              nxt_valid;
    logic [InBits-1:0] nxt_data;
    nxt_valid = s_tvalid;
    nxt_data  = s_tdata;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        rgba_q.push_back(hsl_to_rgba(cur_pix));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (src_gap > 0) begin
          src_gap--;
          src_idle_cycles++;
        end else if (pixel_q.size() > TailBeats && src_calm == 0 &&
                     $urandom_range(0, 5) == 0) begin
          // random idle burst, this cycle included
          src_gap  = $urandom_range(1, 14) - 1;
          src_calm = $urandom_range(0, 60);
          src_idle_cycles++;
        end else if (pixel_q.size() > 0) begin
          cur_pix   = pixel_q.pop_front();
          nxt_valid = 1'b1;
          nxt_data  = InBits'({cur_pix.alpha, cur_pix.light, cur_pix.sat, cur_pix.hue});
          if (src_calm > 0) src_calm--;
        end
      end
    end
    s_tvalid <= nxt_valid;
    s_tdata  <= nxt_data;
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted output beat against the oldest expectation,
  // and applies random back-pressure bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : mon
    logic        nxt_ready;
    rgba_color_t got;
    rgba_color_t want;
    nxt_ready = m_tready;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got.red   = m_tdata[7:0];
        got.green = m_tdata[15:8];
        got.blue  = m_tdata[23:16];
        got.alpha = m_tdata[31:24];
        if (rgba_q.size() == 0) begin
          report_mismatch($sformatf("unexpected output beat 0x%08h", m_tdata));
        end else begin
          want = rgba_q.pop_front();
          checked_count++;
          if (got.red !== want.red)
            report_mismatch($sformatf("red got %0d expected %0d", got.red, want.red));
          if (got.green !== want.green)
            report_mismatch($sformatf("green got %0d expected %0d", got.green, want.green));
          if (got.blue !== want.blue)
            report_mismatch($sformatf("blue got %0d expected %0d", got.blue, want.blue));
          if (got.alpha !== want.alpha)
            report_mismatch($sformatf("alpha got %0d expected %0d", got.alpha, want.alpha));
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        nxt_ready = 1'b0;
        sink_stall_cycles++;
      end else if (pixel_q.size() > TailBeats && sink_calm == 0 &&
                   $urandom_range(0, 6) == 0) begin
        sink_gap  = $urandom_range(1, 14) - 1;
        sink_calm = $urandom_range(0, 60);
        nxt_ready = 1'b0;
        sink_stall_cycles++;
      end else begin
        nxt_ready = 1'b1;
        if (sink_calm > 0) sink_calm--;
      end
    end
    m_tready <= nxt_ready;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stim
    int h;
    int s;
    int l;
    // Directed: hue wrap and sector edges, percent limits, alpha extremes
    queue_pixel(0, 100, 50, 0);
    queue_pixel(30, 100, 50, 255);
    queue_pixel(60, 100, 50, 17);
    queue_pixel(90, 100, 50, 200);
    queue_pixel(119, 100, 50, 1);
    queue_pixel(120, 100, 50, 254);
    queue_pixel(180, 100, 50, 128);
    queue_pixel(240, 100, 50, 127);
    queue_pixel(300, 100, 50, 64);
    queue_pixel(359, 100, 50, 99);
    queue_pixel(360, 100, 50, 255);     // one full turn
    queue_pixel(-1, 100, 50, 0);        // negative hue
    queue_pixel(-360, 100, 50, 33);
    queue_pixel(-32768, 80, 40, 255);   // most negative hue
    queue_pixel(32767, 80, 60, 0);      // most positive hue
    queue_pixel(200, 0, 0, 10);         // black
    queue_pixel(200, 0, 100, 20);       // white
    queue_pixel(45, 127, 127, 255);     // both percents over the limit
    queue_pixel(210, 101, 100, 90);
    queue_pixel(150, 100, 0, 5);
    queue_pixel(270, 127, 101, 6);
    queue_pixel(330, 50, 25, 77);
    queue_pixel(15, 100, 75, 160);
    queue_pixel(110, 25, 4, 42);        // red lands exactly on a rounding half
    directed_count = pixel_q.size();

    // Random: mostly legal percents, some over-range, hue both near and far
    for (int i = 0; i < RandCount; i++) begin
      if ($urandom_range(0, 1) == 0) h = $urandom_range(0, 1440) - 720;
      else h = int'($signed(16'($urandom)));
      if ($urandom_range(0, 4) == 0) begin
        s = $urandom_range(0, 127);
        l = $urandom_range(0, 127);
      end else begin
        s = $urandom_range(0, 100);
        l = $urandom_range(0, 100);
      end
      queue_pixel(h, s, l, $urandom_range(0, 255));
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_q.size() != 0 || s_tvalid) @(posedge clk_i);
    while (rgba_q.size() != 0) @(posedge clk_i);
    // pipeline is six deep; any stray beat would show up well within this
    repeat (20) @(posedge clk_i);

    $display("Checked %0d pixels (%0d directed, %0d random) against the HSL model.",
             checked_count, directed_count, RandCount);
    $display("Source idled %0d cycles, sink stalled %0d cycles, %0d mismatches.",
             src_idle_cycles, sink_stall_cycles, err_count);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #10ms;
    $display("Timeout: %0d colors still expected", rgba_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/hslrgb_pkg.sv
hw/rtl/hslrgb_chan.sv
hw/rtl/hsl_to_rgb_converter.sv
tb/sv/testbench.sv
